@@ sv/choice_em_estep_accumulator_macros.svh @@
// assertion macros for the choice e-step accumulator
`ifndef CHOICE_EM_ESTEP_ACCUMULATOR_MACROS_SVH
`define CHOICE_EM_ESTEP_ACCUMULATOR_MACROS_SVH
`ifndef SYNTHESIS
`define CEA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cea assertion failed");
`define CEA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cea assertion failed");
`else
`define CEA_ASSERT_IMPL(label, ante, cons)
`define CEA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ sv/cea_pkg.sv @@
// shared types and constants of the choice e-step accumulator
`default_nettype none
package cea_pkg;
    localparam int NUM_TYPES         = 8;
    localparam int NUM_OPTIONS       = 7;
    localparam int PERIOD_COUNT_BITS = 22;
    localparam int ACC_W             = PERIOD_COUNT_BITS + 16;
    localparam int SUM_W             = 19;
    localparam int NUM_W             = 35;
    localparam int DIV_W             = 37;
    localparam int Q_W               = 17;
    localparam int PROD_W            = 33;
    localparam int CNT_W             = 5;

    // register indexes
    localparam logic [2:0] REG_RANK_01  = 3'd0;
    localparam logic [2:0] REG_RANK_23  = 3'd1;
    localparam logic [2:0] REG_RANK_45  = 3'd2;
    localparam logic [2:0] REG_RANK_67  = 3'd3;
    localparam logic [2:0] REG_PROB_LO  = 3'd4;
    localparam logic [2:0] REG_PROB_HI  = 3'd5;
    localparam logic [2:0] REG_RATE     = 3'd6;

    localparam logic [63:0] PROB_RESET = 64'd2305878194123661888;
    localparam logic [15:0] RATE_RESET = 16'd19661;

    localparam logic KIND_PERIOD  = 1'b0;
    localparam logic KIND_READOUT = 1'b1;

    typedef struct packed {
        logic [6:0] available_mask;
        logic [2:0] chosen_option;
        logic       last_period;
    } in_t;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  compatible_mask;
        logic [16:0] arrival_estimate;
        logic        no_compatible_purchase;
        logic [2:0]  type_index;
        logic [37:0] weight_sum;
        logic        last_result;
    } out_t;

    typedef enum logic [3:0] {
        S_IDLE, S_EVAL, S_NUM, S_ABR, S_ADIV, S_WSEL, S_WMUL, S_WLOAD, S_WDIV,
        S_EMIT0, S_RD
    } state_t;

    typedef struct packed {
        logic capture;
        logic eval;
        logic num;
        logic adiv_start;
        logic a_load_div;
        logic a_fast;
        logic t_clr;
        logic wmul;
        logic wdiv_start;
        logic wacc;
        logic t_inc;
        logic emit0;
        logic emit_rd;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic need_adiv;
        logic skip_weights;
        logic mask_bit;
        logic t_last;
        logic last_period;
    } sts_t;
endpackage
`default_nettype wire

@@ sv/cea_div.sv @@
// restoring serial divider, one quotient bit per cycle
`default_nettype none
module cea_div (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [cea_pkg::DIV_W-1:0]    r0,
    input  wire logic [cea_pkg::Q_W-1:0]      lo,
    input  wire logic [cea_pkg::DIV_W-1:0]    divisor,
    input  wire logic [cea_pkg::CNT_W-1:0]    nsteps,
    output logic                              done,
    output logic [cea_pkg::Q_W-1:0]           quot
);
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [cea_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [cea_pkg::DIV_W-1:0]   rem_reg, rem_next;
    logic [cea_pkg::Q_W-1:0]     lo_reg, lo_next;
    logic [cea_pkg::Q_W-1:0]     q_reg, q_next;
    logic [cea_pkg::DIV_W-1:0]   div_reg, div_next;
    logic [cea_pkg::DIV_W:0]     shifted;
    logic [cea_pkg::DIV_W:0]     diff;
    logic                        ge;

    // one trial subtraction
    always_comb
    begin
        shifted = {rem_reg, lo_reg[cea_pkg::Q_W-1]};
        diff    = shifted - {1'b0, div_reg};
        ge      = shifted >= {1'b0, div_reg};
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        lo_next   = lo_reg;
        q_next    = q_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = nsteps;
            rem_next  = r0;
            lo_next   = lo;
            q_next    = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[cea_pkg::DIV_W-1:0] : shifted[cea_pkg::DIV_W-1:0];
            lo_next  = {lo_reg[cea_pkg::Q_W-2:0], 1'b0};
            q_next   = {q_reg[cea_pkg::Q_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == cea_pkg::CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // operands
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        lo_reg  <= lo_next;
        q_reg   <= q_next;
        div_reg <= div_next;
    end

    assign done = done_reg;
    assign quot = q_reg;
endmodule
`default_nettype wire

@@ sv/cea_datapath.sv @@
// datapath: compatibility, arrival estimate, weight accumulators, output register
`default_nettype none
module cea_datapath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cea_pkg::cmd_t      cmd,
    input  wire cea_pkg::in_t       in_data,
    input  wire logic [3:0][63:0]   rank_regs,
    input  wire logic [7:0][15:0]   probs,
    input  wire logic [15:0]        lam,
    output cea_pkg::sts_t           sts,
    output cea_pkg::out_t           out_data
);
    cea_pkg::in_t                         in_reg;
    logic [7:0]                           mask_reg, mask_c;
    logic [cea_pkg::SUM_W-1:0]            s_reg, s_c;
    logic [cea_pkg::NUM_W-1:0]            num_reg;
    logic [cea_pkg::Q_W-1:0]              a_reg;
    logic [cea_pkg::PROD_W-1:0]           prod_reg;
    logic [2:0]                           t_reg;
    logic [cea_pkg::NUM_TYPES-1:0][cea_pkg::ACC_W-1:0] acc_reg;
    cea_pkg::out_t                        out_reg;
    logic [cea_pkg::DIV_W-1:0]            den;
    logic                                 flag;
    logic                                 div_done;
    logic [cea_pkg::Q_W-1:0]              div_q;
    logic [cea_pkg::ACC_W:0]              acc_sum;
    logic [cea_pkg::DIV_W-1:0]            d_r0;
    logic [cea_pkg::Q_W-1:0]              d_lo;
    logic [cea_pkg::DIV_W-1:0]            d_div;
    logic [cea_pkg::CNT_W-1:0]            d_steps;

    function automatic logic [3:0] rank_f(input logic [3:0][63:0] r, input logic [2:0] tt,
                                          input logic [2:0] k);
        logic [5:0] sh;
        sh = {tt[0], k, 2'b00};
        return r[tt[2:1]][sh +: 4];
    endfunction

    // compatibility mask and probability sum
    always_comb
    begin
        logic [3:0] rc;
        logic       ok;
        mask_c = '0;
        s_c    = '0;
        for (int t = 0; t < cea_pkg::NUM_TYPES; t++)
        begin
            rc = rank_f(rank_regs, 3'(t), in_reg.chosen_option);
            ok = rank_f(rank_regs, 3'(t), 3'd0) >= rc;
            for (int k = 1; k <= cea_pkg::NUM_OPTIONS; k++)
            begin
                if (in_reg.available_mask[k-1] && (3'(k) != in_reg.chosen_option)
                    && (rank_f(rank_regs, 3'(t), 3'(k)) < rc))
                    ok = 1'b0;
            end
            if (ok)
            begin
                mask_c[t] = 1'b1;
                s_c       = s_c + cea_pkg::SUM_W'(probs[t]);
            end
        end
    end

    assign flag = (in_reg.chosen_option != 3'd0) && (mask_reg == 8'd0);
    assign den  = cea_pkg::DIV_W'(num_reg)
                + cea_pkg::DIV_W'({17'd65536 - {1'b0, lam}, 16'h0000});

    // divider operand select
    always_comb
    begin
        if (cmd.adiv_start)
        begin
            d_r0    = cea_pkg::DIV_W'(num_reg);
            d_lo    = '0;
            d_div   = den;
            d_steps = cea_pkg::CNT_W'(16);
        end
        else
        begin
            d_r0    = cea_pkg::DIV_W'(prod_reg[cea_pkg::PROD_W-1:cea_pkg::Q_W]);
            d_lo    = prod_reg[cea_pkg::Q_W-1:0];
            d_div   = cea_pkg::DIV_W'(s_reg);
            d_steps = cea_pkg::CNT_W'(cea_pkg::Q_W);
        end
    end

    cea_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.adiv_start | cmd.wdiv_start),
        .r0      (d_r0),
        .lo      (d_lo),
        .divisor (d_div),
        .nsteps  (d_steps),
        .done    (div_done),
        .quot    (div_q)
    );

    assign acc_sum = {1'b0, acc_reg[t_reg]} + (cea_pkg::ACC_W+1)'(div_q);

    // item registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            in_reg <= in_data;
        if (cmd.eval)
        begin
            mask_reg <= mask_c;
            s_reg    <= s_c;
        end
        if (cmd.num)
            num_reg <= cea_pkg::NUM_W'(lam) * cea_pkg::NUM_W'(s_reg);
        if (cmd.a_fast)
            a_reg <= (in_reg.chosen_option != 3'd0) ? 17'd65536 : 17'd0;
        else if (cmd.a_load_div)
            a_reg <= div_q;
        if (cmd.wmul)
            prod_reg <= cea_pkg::PROD_W'(a_reg) * cea_pkg::PROD_W'(probs[t_reg]);
    end

    // type counter and accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_reg   <= '0;
            acc_reg <= '0;
        end
        else
        begin
            if (cmd.t_clr)
                t_reg <= '0;
            else if (cmd.t_inc)
                t_reg <= t_reg + 3'd1;
            if (cmd.wacc)
                acc_reg[t_reg] <= acc_sum[cea_pkg::ACC_W] ? '1
                                                          : acc_sum[cea_pkg::ACC_W-1:0];
            else if (cmd.emit_rd)
                acc_reg[t_reg] <= '0;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.emit0)
        begin
            out_reg.result_kind            <= cea_pkg::KIND_PERIOD;
            out_reg.compatible_mask        <= mask_reg;
            out_reg.arrival_estimate       <= a_reg;
            out_reg.no_compatible_purchase <= flag;
            out_reg.type_index             <= '0;
            out_reg.weight_sum             <= '0;
            out_reg.last_result            <= !in_reg.last_period;
        end
        else if (cmd.emit_rd)
        begin
            out_reg.result_kind            <= cea_pkg::KIND_READOUT;
            out_reg.compatible_mask        <= '0;
            out_reg.arrival_estimate       <= '0;
            out_reg.no_compatible_purchase <= 1'b0;
            out_reg.type_index             <= t_reg;
            out_reg.weight_sum             <= 38'(acc_reg[t_reg]);
            out_reg.last_result            <= (t_reg == 3'(cea_pkg::NUM_TYPES-1));
        end
    end

    assign out_data = out_reg;

    // status to controller
    always_comb
    begin
        sts.div_done     = div_done;
        sts.need_adiv    = (in_reg.chosen_option == 3'd0) && (mask_reg != 8'd0);
        sts.skip_weights = flag || (s_reg == '0);
        sts.mask_bit     = mask_reg[t_reg];
        sts.t_last       = (t_reg == 3'(cea_pkg::NUM_TYPES-1));
        sts.last_period  = in_reg.last_period;
    end
endmodule
`default_nettype wire

@@ sv/cea_ctrl.sv @@
// controller state machine sequencing one period and the readout after a last period
`default_nettype none
module cea_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  wire logic           out_stall,
    input  wire cea_pkg::sts_t  sts,
    output cea_pkg::cmd_t       cmd
);
    cea_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;
    logic            out_free;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != cea_pkg::S_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cea_pkg::S_IDLE:  if (in_valid) state_next = cea_pkg::S_EVAL;
            cea_pkg::S_EVAL:  state_next = cea_pkg::S_NUM;
            cea_pkg::S_NUM:   state_next = cea_pkg::S_ABR;
            cea_pkg::S_ABR:   state_next = sts.need_adiv ? cea_pkg::S_ADIV : cea_pkg::S_WSEL;
            cea_pkg::S_ADIV:  if (sts.div_done) state_next = cea_pkg::S_WSEL;
            cea_pkg::S_WSEL:
            begin
                priority if (sts.skip_weights)
                    state_next = cea_pkg::S_EMIT0;
                else if (sts.mask_bit)
                    state_next = cea_pkg::S_WMUL;
                else if (sts.t_last)
                    state_next = cea_pkg::S_EMIT0;
                else
                    state_next = cea_pkg::S_WSEL;
            end
            cea_pkg::S_WMUL:  state_next = cea_pkg::S_WLOAD;
            cea_pkg::S_WLOAD: state_next = cea_pkg::S_WDIV;
            cea_pkg::S_WDIV:
                if (sts.div_done)
                    state_next = sts.t_last ? cea_pkg::S_EMIT0 : cea_pkg::S_WSEL;
            cea_pkg::S_EMIT0:
                if (out_free)
                    state_next = sts.last_period ? cea_pkg::S_RD : cea_pkg::S_IDLE;
            cea_pkg::S_RD:
                if (out_free && sts.t_last) state_next = cea_pkg::S_IDLE;
            default:          state_next = cea_pkg::S_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            cea_pkg::S_IDLE:  cmd.capture = in_valid;
            cea_pkg::S_EVAL:  cmd.eval = 1'b1;
            cea_pkg::S_NUM:
            begin
                cmd.num   = 1'b1;
                cmd.t_clr = 1'b1;
            end
            cea_pkg::S_ABR:
            begin
                cmd.adiv_start = sts.need_adiv;
                cmd.a_fast     = !sts.need_adiv;
            end
            cea_pkg::S_ADIV:  cmd.a_load_div = sts.div_done;
            cea_pkg::S_WSEL:  cmd.t_inc = !sts.skip_weights && !sts.mask_bit;
            cea_pkg::S_WMUL:  cmd.wmul = 1'b1;
            cea_pkg::S_WLOAD: cmd.wdiv_start = 1'b1;
            cea_pkg::S_WDIV:
            begin
                cmd.wacc  = sts.div_done;
                cmd.t_inc = sts.div_done;
            end
            cea_pkg::S_EMIT0:
            begin
                cmd.emit0 = out_free;
                cmd.t_clr = out_free;
            end
            cea_pkg::S_RD:
            begin
                cmd.emit_rd = out_free;
                cmd.t_inc   = out_free;
            end
            default:          cmd = '0;
        endcase
    end

    // output valid
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.emit0 || cmd.emit_rd)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cea_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
endmodule
`default_nettype wire

@@ sv/choice_em_estep_accumulator.sv @@
// top level of the choice-model e-step accumulator
`default_nettype none
`include "choice_em_estep_accumulator_macros.svh"
// One period is taken at a time. After a transfer in, evaluation runs through
// the S_EVAL, S_NUM and S_ABR states; a no-purchase period with a compatible
// type then adds the 16-step serial division of the arrival estimate. Unless
// the weights are skipped, each type then takes only the select state if it
// is skipped, and a multiply, a divider load, a 17-step division by the
// probability sum on the one shared divider and its done step if compatible.
// The per-period result is then loaded into the output register, a last
// period is followed by eight readout results, one per cycle when not
// stalled, and the block returns to idle before the next transfer in.
// Registers sit at byte addresses 8*i on the APB port and read back as
// written, but the rate register keeps only bits 15:0 and index 7 reads 0.
module choice_em_estep_accumulator (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire cea_pkg::in_t  in_data,
    output logic               out_valid,
    input  wire logic          out_stall,
    output cea_pkg::out_t      out_data,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [5:0]    paddr,
    input  wire logic [63:0]   pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);
    logic [3:0][63:0] rank_reg;
    logic [63:0]      prob_lo_reg;
    logic [63:0]      prob_hi_reg;
    logic [15:0]      rate_reg;
    logic             wr;
    logic [2:0]       ridx;
    cea_pkg::cmd_t    cmd;
    cea_pkg::sts_t    sts;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign ridx   = paddr[5:3];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg    <= '0;
            prob_lo_reg <= cea_pkg::PROB_RESET;
            prob_hi_reg <= cea_pkg::PROB_RESET;
            rate_reg    <= cea_pkg::RATE_RESET;
        end
        else if (wr)
        begin
            unique case (ridx)
                cea_pkg::REG_RANK_01: rank_reg[0]  <= pwdata;
                cea_pkg::REG_RANK_23: rank_reg[1]  <= pwdata;
                cea_pkg::REG_RANK_45: rank_reg[2]  <= pwdata;
                cea_pkg::REG_RANK_67: rank_reg[3]  <= pwdata;
                cea_pkg::REG_PROB_LO: prob_lo_reg <= pwdata;
                cea_pkg::REG_PROB_HI: prob_hi_reg <= pwdata;
                cea_pkg::REG_RATE:    rate_reg    <= pwdata[15:0];
                default:              rate_reg    <= rate_reg;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        unique case (ridx)
            cea_pkg::REG_RANK_01: prdata = rank_reg[0];
            cea_pkg::REG_RANK_23: prdata = rank_reg[1];
            cea_pkg::REG_RANK_45: prdata = rank_reg[2];
            cea_pkg::REG_RANK_67: prdata = rank_reg[3];
            cea_pkg::REG_PROB_LO: prdata = prob_lo_reg;
            cea_pkg::REG_PROB_HI: prdata = prob_hi_reg;
            cea_pkg::REG_RATE:    prdata = 64'(rate_reg);
            default:              prdata = '0;
        endcase
    end

    cea_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    cea_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (in_data),
        .rank_regs (rank_reg),
        .probs     ({prob_hi_reg, prob_lo_reg}),
        .lam       (rate_reg),
        .sts       (sts),
        .out_data  (out_data)
    );

    // result consistency checks
    `CEA_ASSERT_IMPL(a_period_fields, out_valid && !out_data.result_kind, (out_data.type_index == 3'd0) && (out_data.weight_sum == 38'd0))
    `CEA_ASSERT_IMPL(a_readout_fields, out_valid && out_data.result_kind, (out_data.compatible_mask == 8'd0) && (out_data.arrival_estimate == 17'd0))
    `CEA_ASSERT_IMPL(a_estimate_range, out_valid && out_data.arrival_estimate[16], out_data.arrival_estimate[15:0] == 16'd0)
    `CEA_ASSERT_IMPL(a_flag_case, out_valid && out_data.no_compatible_purchase, (out_data.compatible_mask == 8'd0) && (out_data.arrival_estimate == 17'd65536))
    `CEA_ASSERT_NEXT(a_busy_stall, in_valid && !in_stall, in_stall)
endmodule
`default_nettype wire
